[rtl/wrs_pkg.sv]
`default_nettype none

package wrs_pkg;

   localparam int TABLE_DEPTH_DEF = 10;
   localparam int WEIGHT_BITS_DEF = 16;

   localparam int FUNC_W   = 1;
   localparam int INDEX_W  = 4;
   localparam int ID_W     = 8;
   localparam int WEIGHT_W = 16;
   localparam int RND_W    = 31;
   localparam int STAT_W   = 2;
   localparam int COUNT_W  = 4;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [COUNT_W-1:0] ENTRY_COUNT_RESET = 4'd0;
   localparam logic [ID_W-1:0]    FALLBACK_ID_RESET = 8'd41;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_LOAD   = 1'b0,
      FUNC_SAMPLE = 1'b1
   } func_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_SAMPLED  = 2'd0,
      STAT_LOADED   = 2'd1,
      STAT_EMPTY    = 2'd2,
      STAT_REJECTED = 2'd3
   } status_type;

   typedef enum logic {
      REG_ENTRY_COUNT = 1'b0,
      REG_FALLBACK_ID = 1'b1
   } reg_index_type;

   typedef enum logic {
      OP_ADD = 1'b0,
      OP_SUB = 1'b1
   } unit_op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM,
      ST_MOD,
      ST_SCAN,
      ST_OUT
   } state_type;

endpackage

`default_nettype wire

[rtl/wrs_req_if.sv]
`default_nettype none

interface wrs_req_if;
   import wrs_pkg::*;

   logic                valid;
   logic                ready;
   logic [FUNC_W-1:0]   func;
   logic [INDEX_W-1:0]  entry_index;
   logic [ID_W-1:0]     entry_id;
   logic [WEIGHT_W-1:0] entry_weight;
   logic [RND_W-1:0]    random_value;

   modport source (
      output valid, func, entry_index, entry_id, entry_weight, random_value,
      input  ready
   );

   modport sink (
      input  valid, func, entry_index, entry_id, entry_weight, random_value,
      output ready
   );
endinterface

`default_nettype wire

[rtl/wrs_rsp_if.sv]
`default_nettype none

interface wrs_rsp_if;
   import wrs_pkg::*;

   logic              valid;
   logic              ready;
   logic [ID_W-1:0]   chosen_id;
   logic [STAT_W-1:0] status;

   modport source (
      output valid, chosen_id, status,
      input  ready
   );

   modport sink (
      input  valid, chosen_id, status,
      output ready
   );
endinterface

`default_nettype wire

[rtl/weighted_random_selector_core.sv]
`default_nettype none
// load word: the result goes through the output stage, the next word is taken once it sits in the output register
// sample word for n active entries (n or weight total 0 gives fallback_id with status empty):
//   weight sum over the table read port, 31 restoring modulo steps, then the scan
// one word in flight; a new word is taken once the result sits in the output register
// reset (synchronous, active high): idle, no result pending, entry_count 0, fallback_id 41
// table contents are not cleared by reset
module weighted_random_selector_core #(
   parameter int TABLE_DEPTH = wrs_pkg::TABLE_DEPTH_DEF,
   parameter int WEIGHT_BITS = wrs_pkg::WEIGHT_BITS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   wrs_req_if.sink                              req_chan,
   wrs_rsp_if.source                            rsp_chan,
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [wrs_pkg::CSR_ADDR_W-1:0]  paddr,
   input  wire logic [wrs_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic      [wrs_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                                 pready
);
   import wrs_pkg::*;

   localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
   localparam int SUM_W  = WEIGHT_BITS + CNT_W;
   localparam int UNIT_W = SUM_W + 1;
   localparam int MCNT_W = $clog2(RND_W);

   // csr
   logic [COUNT_W-1:0] entry_count_ff;
   logic [ID_W-1:0]    fallback_ff;
   logic               csr_wr;
   reg_index_type      csr_reg;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;
   assign csr_reg = reg_index_type'(paddr[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= ENTRY_COUNT_RESET;
         fallback_ff    <= FALLBACK_ID_RESET;
      end else if (csr_wr) begin
         case (csr_reg)
            REG_ENTRY_COUNT: entry_count_ff <= pwdata[COUNT_W-1:0];
            REG_FALLBACK_ID: fallback_ff    <= pwdata[ID_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_reg)
         REG_ENTRY_COUNT: prdata = CSR_DATA_W'(entry_count_ff);
         REG_FALLBACK_ID: prdata = CSR_DATA_W'(fallback_ff);
         default:         prdata = '0;
      endcase
   end

   // sequencer state
   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [CNT_W-1:0]   n_ff, n_in;
   logic               pend_ff, pend_in;
   logic [SUM_W-1:0]   total_ff, total_in;
   logic [SUM_W-1:0]   rem_ff, rem_in;
   logic [RND_W-1:0]   rnd_ff, rnd_in;
   logic [MCNT_W-1:0]  mcnt_ff, mcnt_in;
   logic [ID_W-1:0]    res_id_ff, res_id_in;
   status_type         res_stat_ff, res_stat_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]    rsp_id_ff, rsp_id_in;
   status_type         rsp_stat_ff, rsp_stat_in;

   // table and shared unit
   logic                   tbl_we;
   logic [IDX_W-1:0]       tbl_waddr;
   logic [WEIGHT_BITS-1:0] tbl_wweight;
   logic [ID_W-1:0]        tbl_rid;
   logic [WEIGHT_BITS-1:0] tbl_rweight;
   logic [47:0]            weight_wide;
   logic [UNIT_W-1:0]      unit_a, unit_b, unit_res, w_ext;
   logic                   unit_borrow;
   unit_op_type            unit_op;
   logic                   load_ok;

   assign weight_wide = {32'd0, req_chan.entry_weight};
   assign tbl_wweight = weight_wide[WEIGHT_BITS-1:0];
   assign tbl_waddr   = IDX_W'(req_chan.entry_index);
   assign load_ok     = (32'(req_chan.entry_index) < TABLE_DEPTH) && (tbl_wweight != '0);
   assign w_ext       = UNIT_W'(tbl_rweight);

   wrs_table #(
      .DEPTH       (TABLE_DEPTH),
      .WEIGHT_BITS (WEIGHT_BITS),
      .IDX_W       (IDX_W)
   ) u_table (
      .clock     (clock),
      .wr_en     (tbl_we),
      .wr_addr   (tbl_waddr),
      .wr_id     (req_chan.entry_id),
      .wr_weight (tbl_wweight),
      .rd_addr   (cnt_ff[IDX_W-1:0]),
      .rd_id     (tbl_rid),
      .rd_weight (tbl_rweight)
   );

   wrs_addsub #(
      .WIDTH (UNIT_W)
   ) u_addsub (
      .a      (unit_a),
      .b      (unit_b),
      .op     (unit_op),
      .result (unit_res),
      .borrow (unit_borrow)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      n_ff        <= n_in;
      pend_ff     <= pend_in;
      total_ff    <= total_in;
      rem_ff      <= rem_in;
      rnd_ff      <= rnd_in;
      mcnt_ff     <= mcnt_in;
      res_id_ff   <= res_id_in;
      res_stat_ff <= res_stat_in;
      rsp_id_ff   <= rsp_id_in;
      rsp_stat_ff <= rsp_stat_in;
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      n_in         = n_ff;
      pend_in      = pend_ff;
      total_in     = total_ff;
      rem_in       = rem_ff;
      rnd_in       = rnd_ff;
      mcnt_in      = mcnt_ff;
      res_id_in    = res_id_ff;
      res_stat_in  = res_stat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_id_in    = rsp_id_ff;
      rsp_stat_in  = rsp_stat_ff;
      unit_a       = '0;
      unit_b       = '0;
      unit_op      = OP_ADD;
      tbl_we       = 1'b0;
      req_chan.ready = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               if (func_type'(req_chan.func) == FUNC_LOAD) begin
                  tbl_we      = load_ok;
                  res_id_in   = '0;
                  res_stat_in = load_ok ? STAT_LOADED : STAT_REJECTED;
                  state_in    = ST_OUT;
               end else begin
                  n_in     = (32'(entry_count_ff) > TABLE_DEPTH) ?
                             CNT_W'(TABLE_DEPTH) : CNT_W'(entry_count_ff);
                  cnt_in   = '0;
                  pend_in  = 1'b0;
                  total_in = '0;
                  rnd_in   = req_chan.random_value;
                  state_in = ST_SUM;
               end
            end
         end
         ST_SUM: begin
            unit_a  = {1'b0, total_ff};
            unit_b  = w_ext;
            unit_op = OP_ADD;
            if (pend_ff) begin
               total_in = unit_res[SUM_W-1:0];
            end
            if (cnt_ff < n_ff) begin
               cnt_in  = cnt_ff + CNT_W'(1);
               pend_in = 1'b1;
            end else begin
               pend_in = 1'b0;
            end
            if (cnt_ff == n_ff && !pend_ff) begin
               if (n_ff == '0 || total_ff == '0) begin
                  res_id_in   = fallback_ff;
                  res_stat_in = STAT_EMPTY;
                  state_in    = ST_OUT;
               end else begin
                  rem_in   = '0;
                  mcnt_in  = MCNT_W'(RND_W - 1);
                  state_in = ST_MOD;
               end
            end
         end
         ST_MOD: begin
            // one restoring step: shift in the next random bit, subtract the total
            unit_a  = {rem_ff, rnd_ff[RND_W-1]};
            unit_b  = {1'b0, total_ff};
            unit_op = OP_SUB;
            rem_in  = unit_borrow ? unit_a[SUM_W-1:0] : unit_res[SUM_W-1:0];
            rnd_in  = rnd_ff << 1;
            mcnt_in = mcnt_ff - MCNT_W'(1);
            if (mcnt_ff == '0) begin
               cnt_in   = '0;
               pend_in  = 1'b0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // remainder below the entry weight selects that entry
            unit_a  = {1'b0, rem_ff};
            unit_b  = w_ext;
            unit_op = OP_SUB;
            if (cnt_ff < n_ff) begin
               cnt_in  = cnt_ff + CNT_W'(1);
               pend_in = 1'b1;
            end else begin
               pend_in = 1'b0;
            end
            if (pend_ff) begin
               if (unit_borrow) begin
                  res_id_in   = tbl_rid;
                  res_stat_in = STAT_SAMPLED;
                  state_in    = ST_OUT;
               end else begin
                  rem_in = unit_res[SUM_W-1:0];
               end
            end else if (cnt_ff == n_ff) begin
               res_id_in   = fallback_ff;
               res_stat_in = STAT_EMPTY;
               state_in    = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_id_in    = res_id_ff;
               rsp_stat_in  = res_stat_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.chosen_id = rsp_id_ff;
   assign rsp_chan.status    = rsp_stat_ff;

`ifndef SYNTHESIS
   a_load_to_out: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && req_chan.func == FUNC_LOAD) |=> state_ff == ST_OUT)
      else $error("load word did not go straight to the output stage");

   a_rem_below_total: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MOD || state_ff == ST_SCAN) |-> rem_ff < total_ff)
      else $error("remainder not below weight total");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SUM || state_ff == ST_SCAN) |-> cnt_ff <= n_ff)
      else $error("entry counter beyond active count");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("second word taken while one is in flight");
`endif

endmodule

`default_nettype wire

[rtl/wrs_table.sv]
`default_nettype none

module wrs_table #(
   parameter int DEPTH       = wrs_pkg::TABLE_DEPTH_DEF,
   parameter int WEIGHT_BITS = wrs_pkg::WEIGHT_BITS_DEF,
   parameter int IDX_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                    clock,
   input  wire logic                    wr_en,
   input  wire logic [IDX_W-1:0]        wr_addr,
   input  wire logic [wrs_pkg::ID_W-1:0] wr_id,
   input  wire logic [WEIGHT_BITS-1:0]  wr_weight,
   input  wire logic [IDX_W-1:0]        rd_addr,
   output logic      [wrs_pkg::ID_W-1:0] rd_id,
   output logic      [WEIGHT_BITS-1:0]  rd_weight
);
   import wrs_pkg::*;

   logic [ID_W-1:0]        id_mem     [DEPTH];
   logic [WEIGHT_BITS-1:0] weight_mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         id_mem[wr_addr]     <= wr_id;
         weight_mem[wr_addr] <= wr_weight;
      end
   end

   always_ff @(posedge clock) begin
      rd_id     <= id_mem[rd_addr];
      rd_weight <= weight_mem[rd_addr];
   end

endmodule

`default_nettype wire

[rtl/wrs_addsub.sv]
`default_nettype none

module wrs_addsub #(
   parameter int WIDTH = 32
) (
   input  wire logic [WIDTH-1:0]          a,
   input  wire logic [WIDTH-1:0]          b,
   input  wire wrs_pkg::unit_op_type      op,
   output logic      [WIDTH-1:0]          result,
   output logic                           borrow
);
   import wrs_pkg::*;

   logic             sub;
   logic [WIDTH-1:0] b_eff;
   logic             carry;

   assign sub   = (op == OP_SUB);
   assign b_eff = sub ? ~b : b;
   assign {carry, result} = {1'b0, a} + {1'b0, b_eff} + {{WIDTH{1'b0}}, sub};
   // a below b when subtracting
   assign borrow = sub & ~carry;

endmodule

`default_nettype wire
